FILE: sv/rpn_pkg.sv
package rpn_pkg;

	localparam int DATA_W = 32;
	localparam int KIND_W = 3;
	localparam int VIDX_W = 5;
	// Variable numbers are compared against NUM_VARS at this width (NUM_VARS <= 511)
	localparam int VCMP_W = 9;

	// Input kind codes
	localparam logic [KIND_W-1:0] KIND_ASSIGN   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH_VAR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PUSH_VAL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PRINT    = 3'd4;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_UNDER  = 3'd1,
		ST_OVER   = 3'd2,
		ST_DIV0   = 3'd3,
		ST_NOTVAR = 3'd4
	} status_t;

	// Token class decided by the front end
	typedef enum logic [2:0] {
		CLS_NOP,
		CLS_ASSIGN,
		CLS_OPER,
		CLS_PUSH_REF,
		CLS_PUSH_VAL,
		CLS_PRINT
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		op_t               op;
		logic [DATA_W-1:0] data;
	} tok_t;

	typedef struct packed {
		logic valid;
		tok_t tok;
	} qif_t;

	// Stack entry: tag plus value or variable number
	typedef struct packed {
		logic              is_ref;
		logic [DATA_W-1:0] data;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_TOP,
		S_RES_TOP,
		S_RES_SEC,
		S_DIV,
		S_WB
	} exec_state_t;

endpackage

FILE: sv/rpn_ram.sv
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/rpn_front.sv
module rpn_front
	import rpn_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KIND_W-1:0]        kind,
	input  logic [1:0]               op_code,
	input  logic [VIDX_W-1:0]        var_index,
	input  logic signed [DATA_W-1:0] literal,
	output qif_t                     q,
	input  logic                     q_pop
);

	tok_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	tok_t       new_tok;
	logic       push;
	logic       pop;

	// Classify the incoming item
	always_comb begin
		new_tok.op   = op_t'(op_code);
		new_tok.data = literal;
		unique case (kind)
			KIND_ASSIGN:   new_tok.cls = CLS_ASSIGN;
			KIND_OPERATOR: new_tok.cls = CLS_OPER;
			KIND_PUSH_VAR: begin
				new_tok.cls  = CLS_PUSH_REF;
				new_tok.data = {{(DATA_W-VIDX_W){1'b0}}, var_index};
			end
			KIND_PUSH_VAL: new_tok.cls = CLS_PUSH_VAL;
			KIND_PRINT:    new_tok.cls = CLS_PRINT;
			default:       new_tok.cls = CLS_NOP;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && (fill_q != 2'd0);

	assign q.valid = (fill_q != 2'd0);
	assign q.tok   = fifo_q[rd_ptr_q];

	// Two-entry token queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_tok;
		end
	end

endmodule

FILE: sv/rpn_div.sv
module rpn_div
	import rpn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int STEPS = DATA_W;
	localparam int SW = $clog2(STEPS + 1);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dsr_q;
	logic [SW-1:0]     step_q;
	logic              neg_q;
	logic              done_q;
	logic [DATA_W:0]   rem_sh;
	logic              ge;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;

	// Magnitudes of the signed operands
	assign mag_a = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
	assign mag_b = divisor[DATA_W-1]  ? (DATA_W'(0) - divisor)  : divisor;

	// One restoring step per cycle
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign ge     = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= SW'(STEPS);
			end else if (step_q != '0) begin
				step_q <= step_q - SW'(1);
				done_q <= (step_q == SW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dsr_q <= mag_b;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (step_q != '0) begin
			rem_q <= ge ? DATA_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

FILE: sv/rpn_exec.sv
module rpn_exec
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int NUM_VARS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qif_t                     q,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     print_valid,
	output logic signed [DATA_W-1:0] print_value,
	output logic [2:0]               status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

	exec_state_t       state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	tok_t              tok_q, tok_d;
	entry_t            top_q, top_d;
	logic [DATA_W-1:0] b_q, b_d;
	logic [DATA_W-1:0] r_q, r_d;
	logic              res_valid_q, res_valid_d;
	logic              res_pvalid_q, res_pvalid_d;
	logic [DATA_W-1:0] res_pval_q, res_pval_d;
	status_t           res_status_q, res_status_d;
	logic [NUM_VARS-1:0] vvalid_q;
	logic              vok_q;

	logic [CW-1:0]      cm1, cm2;
	logic               s_we;
	logic [AW-1:0]      s_waddr, s_raddr;
	logic [ENTRY_W-1:0] s_wdata, s_rdata;
	entry_t             s_entry;
	logic               v_we;
	logic [VW-1:0]      v_waddr, v_raddr;
	logic [DATA_W-1:0]  v_wdata, v_rdata;
	logic [VIDX_W-1:0]  ridx;
	logic [VCMP_W-1:0]  ridx_ext, widx_ext;
	logic               r_in_range, w_in_range;
	logic [DATA_W-1:0]  rv;
	logic               div_start, div_done;
	logic [DATA_W-1:0]  div_q;

	assign cm1     = cnt_q - CW'(1);
	assign cm2     = cnt_q - CW'(2);
	assign s_entry = entry_t'(s_rdata);

	// Variable table address decode for read and write
	assign ridx_ext   = {{(VCMP_W-VIDX_W){1'b0}}, ridx};
	assign r_in_range = (ridx_ext < VCMP_W'(NUM_VARS));
	assign v_raddr    = ridx_ext[VW-1:0];
	assign widx_ext   = {{(VCMP_W-VIDX_W){1'b0}}, s_entry.data[VIDX_W-1:0]};
	assign w_in_range = (widx_ext < VCMP_W'(NUM_VARS));
	assign v_waddr    = widx_ext[VW-1:0];

	// Resolved value of the entry held in top_q
	assign rv = top_q.is_ref ? (vok_q ? v_rdata : '0) : top_q.data;

	rpn_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	rpn_ram #(.WIDTH(DATA_W), .DEPTH(NUM_VARS)) u_vars (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rv),
		.divisor  (b_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Sequencer: next state and datapath controls
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		tok_d        = tok_q;
		top_d        = top_q;
		b_d          = b_q;
		r_d          = r_q;
		res_valid_d  = res_valid_q && !out_ready;
		res_pvalid_d = res_pvalid_q;
		res_pval_d   = res_pval_q;
		res_status_d = res_status_q;
		q_pop        = 1'b0;
		s_we         = 1'b0;
		s_waddr      = cm2[AW-1:0];
		s_wdata      = '0;
		s_raddr      = cm1[AW-1:0];
		v_we         = 1'b0;
		v_wdata      = rv;
		ridx         = '0;
		div_start    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (q.valid && !res_valid_q) begin
					q_pop        = 1'b1;
					tok_d        = q.tok;
					res_pvalid_d = 1'b0;
					res_pval_d   = '0;
					res_status_d = ST_OK;
					unique case (q.tok.cls)
						CLS_PUSH_REF, CLS_PUSH_VAL: begin
							res_valid_d = 1'b1;
							if (cnt_q == CW'(STACK_DEPTH)) begin
								res_status_d = ST_OVER;
							end else begin
								s_we    = 1'b1;
								s_waddr = cnt_q[AW-1:0];
								s_wdata = {q.tok.cls == CLS_PUSH_REF, q.tok.data};
								cnt_d   = cnt_q + CW'(1);
							end
						end
						CLS_PRINT: begin
							if (cnt_q == '0) begin
								res_valid_d  = 1'b1;
								res_status_d = ST_UNDER;
							end else begin
								state_d = S_RD_TOP;
							end
						end
						CLS_OPER, CLS_ASSIGN: begin
							if (cnt_q < CW'(2)) begin
								res_valid_d  = 1'b1;
								res_status_d = ST_UNDER;
							end else begin
								state_d = S_RD_TOP;
							end
						end
						default: res_valid_d = 1'b1;
					endcase
				end
			end
			S_RD_TOP: begin
				top_d   = s_entry;
				ridx    = s_entry.data[VIDX_W-1:0];
				s_raddr = cm2[AW-1:0];
				state_d = S_RES_TOP;
			end
			S_RES_TOP: begin
				b_d = rv;
				priority case (tok_q.cls)
					CLS_PRINT: begin
						res_valid_d  = 1'b1;
						res_pvalid_d = 1'b1;
						res_pval_d   = rv;
						cnt_d        = cm1;
						state_d      = S_IDLE;
					end
					CLS_ASSIGN: begin
						res_valid_d = 1'b1;
						state_d     = S_IDLE;
						if (!s_entry.is_ref) begin
							res_status_d = ST_NOTVAR;
						end else begin
							v_we  = w_in_range;
							cnt_d = cm2;
						end
					end
					default: begin
						top_d   = s_entry;
						ridx    = s_entry.data[VIDX_W-1:0];
						state_d = S_RES_SEC;
					end
				endcase
			end
			S_RES_SEC: begin
				unique case (tok_q.op)
					OP_ADD: begin
						r_d     = rv + b_q;
						state_d = S_WB;
					end
					OP_SUB: begin
						r_d     = rv - b_q;
						state_d = S_WB;
					end
					OP_MUL: begin
						r_d     = rv * b_q;
						state_d = S_WB;
					end
					OP_DIV: begin
						if (b_q == '0) begin
							res_valid_d  = 1'b1;
							res_status_d = ST_DIV0;
							state_d      = S_IDLE;
						end else begin
							div_start = 1'b1;
							state_d   = S_DIV;
						end
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					r_d     = div_q;
					state_d = S_WB;
				end
			end
			S_WB: begin
				s_we        = 1'b1;
				s_wdata     = {1'b0, r_q};
				cnt_d       = cm1;
				res_valid_d = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			vvalid_q    <= '0;
		end else begin
			cnt_q       <= cnt_d;
			res_valid_q <= res_valid_d;
			if (v_we) begin
				vvalid_q[v_waddr] <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		tok_q        <= tok_d;
		top_q        <= top_d;
		b_q          <= b_d;
		r_q          <= r_d;
		res_pvalid_q <= res_pvalid_d;
		res_pval_q   <= res_pval_d;
		res_status_q <= res_status_d;
		// a variable never written reads as zero
		vok_q        <= r_in_range && vvalid_q[v_raddr];
	end

	assign out_valid   = res_valid_q;
	assign print_valid = res_pvalid_q;
	assign print_value = res_pval_q;
	assign status      = res_status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");

	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_pvalid_q) |-> (res_status_q == ST_OK))
		else $error("printed item carries an error status");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide wait");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == S_IDLE && !res_valid_q))
		else $error("token taken while busy or result pending");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && (q.tok.cls == CLS_PUSH_VAL || q.tok.cls == CLS_PUSH_REF)
			&& cnt_q != CW'(STACK_DEPTH)) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("push did not grow the stack");

endmodule

FILE: sv/rpn_stack_evaluator.sv
// Accept to result valid: the item is registered in the queue, then taken in S_IDLE;
// pushes, no-ops and early errors end there, print and assign in S_RES_TOP, divide
// by zero in S_RES_SEC, add/sub/mul in S_WB, and divide in S_WB after S_DIV.
// Each item runs alone until its result is taken; the divider gives one bit per cycle.
// A two-entry queue lets inputs arrive while the executor or output stalls.
// arst_n clears the stack count, variable valid bits and all handshake state.
module rpn_stack_evaluator
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int NUM_VARS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KIND_W-1:0]        kind,
	input  logic [1:0]               op_code,
	input  logic [VIDX_W-1:0]        var_index,
	input  logic signed [DATA_W-1:0] literal,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     print_valid,
	output logic signed [DATA_W-1:0] print_value,
	output logic [2:0]               status
);

	qif_t tq;
	logic t_pop;

	rpn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.op_code   (op_code),
		.var_index (var_index),
		.literal   (literal),
		.q         (tq),
		.q_pop     (t_pop)
	);

	rpn_exec #(.STACK_DEPTH(STACK_DEPTH), .NUM_VARS(NUM_VARS)) u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.q           (tq),
		.q_pop       (t_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.print_valid (print_valid),
		.print_value (print_value),
		.status      (status)
	);

endmodule

FILE: bench/rpn_outcome_scoreboard.sv
// Watches both channels of the evaluator, runs its own copy of the operand stack
// and variable store on every accepted item, and compares each result in order.
module rpn_outcome_scoreboard
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int NUM_VARS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [KIND_W-1:0]        kind,
	input  logic [1:0]               op_code,
	input  logic [VIDX_W-1:0]        var_index,
	input  logic signed [DATA_W-1:0] literal,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic                     print_valid,
	input  logic signed [DATA_W-1:0] print_value,
	input  logic [2:0]               status,
	output int                       mismatch_count,
	output int                       pending_results
);

	typedef struct {
		logic              printed;
		logic [DATA_W-1:0] value;
		status_t           code;
	} token_outcome_t;

	entry_t            eval_stack [STACK_DEPTH];
	int unsigned       stack_used;
	logic [DATA_W-1:0] var_store [NUM_VARS];
	token_outcome_t    token_outcomes [$];

	// A reference reads the variable store; numbers past the store read as zero
	function automatic logic [DATA_W-1:0] resolve_entry(entry_t e);
		if (!e.is_ref)
			return e.data;
		if (e.data < NUM_VARS)
			return var_store[e.data];
		return '0;
	endfunction

	// Signed division, truncating toward zero, 32-bit wrap
	function automatic logic [DATA_W-1:0] trunc_divide(logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] mag_a, mag_b, q;
		mag_a = a[DATA_W-1] ? -a : a;
		mag_b = b[DATA_W-1] ? -b : b;
		q = mag_a / mag_b;
		return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
	endfunction

	// Apply one item to the local stack and queue the result it should give
	function automatic void execute_token(logic [KIND_W-1:0] k, op_t o,
			logic [VIDX_W-1:0] vi, logic [DATA_W-1:0] lit);
		token_outcome_t    res;
		entry_t            dst;
		logic [DATA_W-1:0] a, b, r;
		res.printed = 1'b0;
		res.value = '0;
		res.code = ST_OK;
		case (k)
			KIND_ASSIGN: begin
				if (stack_used < 2) begin
					res.code = ST_UNDER;
				end else begin
					dst = eval_stack[stack_used-2];
					if (!dst.is_ref) begin
						res.code = ST_NOTVAR;
					end else begin
						b = resolve_entry(eval_stack[stack_used-1]);
						if (dst.data < NUM_VARS)
							var_store[dst.data] = b;
						stack_used -= 2;
					end
				end
			end
			KIND_OPERATOR: begin
				if (stack_used < 2) begin
					res.code = ST_UNDER;
				end else begin
					b = resolve_entry(eval_stack[stack_used-1]);
					a = resolve_entry(eval_stack[stack_used-2]);
					if (o == OP_DIV && b == '0) begin
						res.code = ST_DIV0;
					end else begin
						case (o)
							OP_ADD: r = a + b;
							OP_SUB: r = a - b;
							OP_MUL: r = a * b;
							default: r = trunc_divide(a, b);
						endcase
						stack_used -= 1;
						eval_stack[stack_used-1].is_ref = 1'b0;
						eval_stack[stack_used-1].data = r;
					end
				end
			end
			KIND_PUSH_VAR, KIND_PUSH_VAL: begin
				if (stack_used >= STACK_DEPTH) begin
					res.code = ST_OVER;
				end else begin
					eval_stack[stack_used].is_ref = (k == KIND_PUSH_VAR);
					eval_stack[stack_used].data = (k == KIND_PUSH_VAR) ? DATA_W'(vi) : lit;
					stack_used += 1;
				end
			end
			KIND_PRINT: begin
				if (stack_used < 1) begin
					res.code = ST_UNDER;
				end else begin
					res.value = resolve_entry(eval_stack[stack_used-1]);
					res.printed = 1'b1;
					stack_used -= 1;
				end
			end
			default: begin
				// unused kind codes do nothing
			end
		endcase
		token_outcomes.push_back(res);
	endfunction

	// Compare first, then predict: no result can belong to an item of this same edge
	always @(posedge clk or negedge arst_n) begin
		token_outcome_t want;
		if (!arst_n) begin
			stack_used = 0;
			foreach (var_store[i])
				var_store[i] = '0;
			token_outcomes.delete();
			mismatch_count = 0;
			pending_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (token_outcomes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("[%0t] unexpected result: printed=%0b value=%0d status=%0d",
							$time, print_valid, print_value, status);
				end else begin
					want = token_outcomes.pop_front();
					if (print_valid !== want.printed || print_value !== want.value ||
							status !== want.code) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("[%0t] result mismatch: expected printed=%0b value=%0d ",
								$time, want.printed, $signed(want.value));
							$display("status=%s, got printed=%0b value=%0d status=%0d",
								want.code.name(), print_valid, print_value, status);
						end
					end
				end
			end
			if (in_valid && in_ready)
				execute_token(kind, op_t'(op_code), var_index, literal);
			pending_results = token_outcomes.size();
		end
	end

endmodule

FILE: bench/rpn_stack_evaluator_tb.sv
module rpn_stack_evaluator_tb;
	import rpn_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int NUM_VARS = 32;
	localparam int RANDOM_TOKENS = 1450;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 600000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [KIND_W-1:0]        kind;
	logic [1:0]               op_code;
	logic [VIDX_W-1:0]        var_index;
	logic signed [DATA_W-1:0] literal;
	logic                     out_valid;
	logic                     out_ready;
	logic                     print_valid;
	logic signed [DATA_W-1:0] print_value;
	logic [2:0]               status;

	int mismatch_count;
	int pending_results;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int tokens_counted = 0;
	bit hold_request = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	rpn_stack_evaluator #(
		.STACK_DEPTH(STACK_DEPTH),
		.NUM_VARS(NUM_VARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.op_code(op_code),
		.var_index(var_index),
		.literal(literal),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.print_valid(print_valid),
		.print_value(print_value),
		.status(status)
	);

	rpn_outcome_scoreboard #(
		.STACK_DEPTH(STACK_DEPTH),
		.NUM_VARS(NUM_VARS)
	) outcome_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.op_code(op_code),
		.var_index(var_index),
		.literal(literal),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.print_valid(print_valid),
		.print_value(print_value),
		.status(status),
		.mismatch_count(mismatch_count),
		.pending_results(pending_results)
	);

	// Result side: random stalls, or a long hold-off when requested
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// Offer one item at a falling edge, return at the falling edge after acceptance
	task automatic send_token(logic [KIND_W-1:0] k, logic [1:0] o, logic [VIDX_W-1:0] vi,
			logic [DATA_W-1:0] lit);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		op_code <= o;
		var_index <= vi;
		literal <= lit;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		if (k <= KIND_PRINT)
			tokens_counted++;
	endtask

	// Fields a kind does not use carry random bits
	task automatic push_value(logic [DATA_W-1:0] lit);
		send_token(KIND_PUSH_VAL, 2'($urandom_range(3)), VIDX_W'($urandom_range(31)), lit);
	endtask

	task automatic push_variable(logic [VIDX_W-1:0] vi);
		send_token(KIND_PUSH_VAR, 2'($urandom_range(3)), vi, $urandom());
	endtask

	task automatic apply_op(op_t o);
		send_token(KIND_OPERATOR, o, VIDX_W'($urandom_range(31)), $urandom());
	endtask

	task automatic send_plain(logic [KIND_W-1:0] k);
		send_token(k, 2'($urandom_range(3)), VIDX_W'($urandom_range(31)), $urandom());
	endtask

	function automatic logic [DATA_W-1:0] pick_literal();
		case ($urandom_range(5))
			0, 1: return $urandom();
			2: return DATA_W'($urandom_range(16)) - 8;
			3: return '0;
			4: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0000_0001;
				endcase
			end
			default: return DATA_W'($urandom_range(1000));
		endcase
	endfunction

	// Favor a few variables so stored values get read back
	function automatic logic [VIDX_W-1:0] pick_var();
		return $urandom_range(1) ? VIDX_W'($urandom_range(31)) : VIDX_W'($urandom_range(3));
	endfunction

	task automatic push_leaf();
		if ($urandom_range(2) == 0)
			push_variable(pick_var());
		else
			push_value(pick_literal());
	endtask

	// Left-deep chain of one to four operands
	task automatic push_expression();
		int n;
		n = $urandom_range(1, 4);
		push_leaf();
		repeat (n - 1) begin
			push_leaf();
			apply_op(op_t'($urandom_range(3)));
		end
	endtask

	task automatic drain_stack();
		repeat (STACK_DEPTH + 2)
			send_plain(KIND_PRINT);
	endtask

	// Mostly well-formed statements; the rest noise, broken sequences, fill and drain
	task automatic random_statement();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			push_expression();
			send_plain(KIND_PRINT);
		end else if (pick < 70) begin
			push_variable(pick_var());
			push_expression();
			send_plain(KIND_ASSIGN);
		end else if (pick < 78) begin
			repeat ($urandom_range(1, 4))
				send_token(KIND_W'($urandom_range(7)), 2'($urandom_range(3)),
					VIDX_W'($urandom_range(31)), $urandom());
		end else if (pick < 88) begin
			case ($urandom_range(2))
				0: push_expression();
				1: apply_op(op_t'($urandom_range(3)));
				default: begin
					push_value(pick_literal());
					push_expression();
					send_plain(KIND_ASSIGN);
				end
			endcase
		end else if (pick < 95) begin
			drain_stack();
		end else begin
			repeat (STACK_DEPTH + 1)
				push_leaf();
			drain_stack();
		end
	endtask

	initial begin
		int phase_target;
		bit hold_done;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		op_code = '0;
		var_index = '0;
		literal = '0;
		hold_done = 1'b0;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: errors on an empty stack, unused kinds
		send_plain(KIND_PRINT);
		apply_op(OP_ADD);
		send_plain(KIND_ASSIGN);
		send_plain(3'd5);
		send_plain(3'd6);
		send_plain(3'd7);
		// most negative divided by minus one
		push_value(32'h8000_0000);
		push_value(32'hFFFF_FFFF);
		apply_op(OP_DIV);
		// assign onto a plain value, then subtract an unset variable
		push_variable(5'd31);
		send_plain(KIND_ASSIGN);
		apply_op(OP_SUB);
		// divide by zero leaves the stack alone
		push_value(32'd0);
		apply_op(OP_DIV);
		apply_op(OP_MUL);
		// assign and read back, including a reference as the stored value
		push_variable(5'd0);
		push_value(32'h7FFF_FFFF);
		send_plain(KIND_ASSIGN);
		push_variable(5'd0);
		send_plain(KIND_PRINT);
		push_variable(5'd5);
		push_variable(5'd0);
		send_plain(KIND_ASSIGN);
		push_variable(5'd5);
		send_plain(KIND_PRINT);
		send_plain(KIND_PRINT);

		// Random phases with different idling on each side
		for (int ph = 0; ph < 4; ph++) begin
			// let the block empty out between phases
			in_valid <= 1'b0;
			@(negedge clk);
			while (pending_results != 0)
				@(negedge clk);
			case (ph)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 50;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 50;
				end
				default: begin
					sender_idle_pct = 24;
					receiver_stall_pct = 24;
				end
			endcase
			phase_target = tokens_counted + RANDOM_TOKENS / 4;
			hold_done = 1'b0;
			while (tokens_counted < phase_target) begin
				random_statement();
				// long result hold-off while items keep coming, once per such phase
				if ((ph == 0 || ph == 2) && !hold_done &&
						tokens_counted >= phase_target - RANDOM_TOKENS / 8) begin
					hold_done = 1'b1;
					in_valid <= 1'b0;
					@(posedge clk);
					hold_request = 1'b1;
					@(negedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		receiver_stall_pct = 0;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);
		repeat (60)
			@(negedge clk);

		if (mismatch_count == 0 && pending_results == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
sv/rpn_pkg.sv
sv/rpn_ram.sv
sv/rpn_front.sv
sv/rpn_div.sv
sv/rpn_exec.sv
sv/rpn_stack_evaluator.sv
bench/rpn_outcome_scoreboard.sv
bench/rpn_stack_evaluator_tb.sv
